FILE: sv/tcp_connection_table_macros.svh
// Assertion macros for the connection table.
`ifndef TCP_CONNECTION_TABLE_MACROS_SVH
`define TCP_CONNECTION_TABLE_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define TCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Property checked without reset masking.
`define TCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

FILE: sv/tct_pkg.sv
package tct_pkg;
    localparam int EntryCount = 16;
    localparam int IdxW = (EntryCount > 1) ? $clog2(EntryCount) : 1;
    localparam int CntW = $clog2(EntryCount + 1);

    typedef enum logic [2:0] {
        CMD_ALLOC  = 3'd0,
        CMD_FREE   = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_LOOKUP = 3'd3,
        CMD_PORT   = 3'd4,
        CMD_GET    = 3'd5
    } t_cmd;

    localparam logic [3:0] StFree   = 4'd0;
    localparam logic [3:0] StClosed = 4'd1;
    localparam logic [3:0] StListen = 4'd2;
    localparam logic [31:0] AddrWild = 32'h0000_0000;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  entry_index;
        logic        in_range;
        logic [31:0] local_addr;
        logic [15:0] local_port;
        logic        foreign_given;
        logic [31:0] foreign_addr;
        logic [15:0] remote_port;
        logic [3:0]  new_state;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic [7:0] index;
        logic [3:0] state;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;
endpackage

FILE: sv/tct_front.sv
module tct_front import tct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [111:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_req        o_req
);
    // Two-entry queue between decode and execution.
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req       w_req;
    logic       w_push, w_pop;

    always_comb begin
        w_req.command       = i_data[2:0];
        w_req.entry_index   = i_data[10:3];
        w_req.in_range      = ({1'b0, i_data[10:3]} < 9'(EntryCount));
        w_req.local_addr    = i_data[42:11];
        w_req.local_port    = i_data[58:43];
        w_req.foreign_given = i_data[59];
        w_req.foreign_addr  = i_data[91:60];
        w_req.remote_port   = i_data[107:92];
        w_req.new_state     = i_data[111:108];
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

FILE: sv/tct_engine.sv
module tct_engine import tct_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_req  i_req,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_res
);
    logic [31:0] r_laddr [EntryCount];
    logic [15:0] r_lport [EntryCount];
    logic [31:0] r_faddr [EntryCount];
    logic [15:0] r_fport [EntryCount];
    logic [3:0]  r_stat  [EntryCount];

    t_state r_state, n_state;
    t_req   r_req;
    logic [CntW-1:0] r_i;
    logic   r_lis_v;
    logic [IdxW-1:0] r_lis_i;
    t_res   r_res, n_res;
    logic   r_ov;

    logic [IdxW-1:0] w_i;
    logic [IdxW-1:0] w_idx;
    logic w_last, w_lm, w_fm, w_lis, w_found;

    assign w_i    = r_i[IdxW-1:0];
    assign w_idx  = r_req.entry_index[IdxW-1:0];
    assign w_last = (r_i == CntW'(EntryCount - 1));
    assign w_lm   = (r_laddr[w_i] == AddrWild || r_laddr[w_i] == r_req.local_addr)
                    && r_lport[w_i] == r_req.local_port;
    assign w_fm   = r_faddr[w_i] == r_req.foreign_addr && r_fport[w_i] == r_req.remote_port;
    assign w_lis  = r_stat[w_i] == StListen && r_faddr[w_i] == AddrWild
                    && r_fport[w_i] == 16'd0;

    always_comb begin
        w_found = 1'b0;
        case (r_req.command)
            CMD_ALLOC:  w_found = (r_stat[w_i] == StFree);
            CMD_LOOKUP: w_found = w_lm && (!r_req.foreign_given || w_fm);
            CMD_PORT:   w_found = (r_lport[w_i] == r_req.local_port);
            default:    w_found = 1'b0;
        endcase
    end

    always_comb begin
        n_res = '0;
        case (r_req.command)
            CMD_FREE: if (r_req.in_range) begin
                n_res = '{1'b1, r_req.entry_index, StFree};
            end
            CMD_WRITE: if (r_req.in_range) begin
                n_res = '{1'b1, r_req.entry_index, r_req.new_state};
            end
            CMD_GET: if (r_req.in_range && r_stat[w_idx] != StFree) begin
                n_res = '{1'b1, r_req.entry_index, r_stat[w_idx]};
            end
            CMD_ALLOC: if (w_found) begin
                n_res = '{1'b1, 8'(w_i), StClosed};
            end
            CMD_LOOKUP: begin
                if (w_found) begin
                    n_res = '{1'b1, 8'(w_i), r_stat[w_i]};
                end else if (w_last) begin
                    if (w_lm && r_req.foreign_given && w_lis)
                        n_res = '{1'b1, 8'(w_i), r_stat[w_i]};
                    else if (r_lis_v)
                        n_res = '{1'b1, 8'(r_lis_i), r_stat[r_lis_i]};
                end
            end
            CMD_PORT: if (w_found) begin
                n_res = '{1'b1, 8'(w_i), r_stat[w_i]};
            end
            default: n_res = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: begin
                if (r_req.command == CMD_FREE || r_req.command == CMD_WRITE
                    || r_req.command == CMD_GET || r_req.command > CMD_GET
                    || w_found || w_last) n_state = S_DONE;
            end
            S_DONE: if (!r_ov) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int k = 0; k < EntryCount; k++) begin
                r_laddr[k] <= '0;
                r_lport[k] <= '0;
                r_faddr[k] <= '0;
                r_fport[k] <= '0;
                r_stat[k]  <= StFree;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN && n_state == S_DONE) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            if (r_state == S_IDLE && i_valid) begin
                r_req   <= i_req;
                r_i     <= '0;
                r_lis_v <= 1'b0;
                r_lis_i <= '0;
            end
            if (r_state == S_SCAN) begin
                r_res <= n_res;
                case (r_req.command)
                    CMD_FREE: if (r_req.in_range) begin
                        r_laddr[w_idx] <= '0;
                        r_lport[w_idx] <= '0;
                        r_faddr[w_idx] <= '0;
                        r_fport[w_idx] <= '0;
                        r_stat[w_idx]  <= StFree;
                    end
                    CMD_WRITE: if (r_req.in_range) begin
                        r_laddr[w_idx] <= r_req.local_addr;
                        r_lport[w_idx] <= r_req.local_port;
                        r_faddr[w_idx] <= r_req.foreign_addr;
                        r_fport[w_idx] <= r_req.remote_port;
                        r_stat[w_idx]  <= r_req.new_state;
                    end
                    CMD_ALLOC: if (w_found) begin
                        r_stat[w_i] <= StClosed;
                    end
                    CMD_LOOKUP: if (w_lm && r_req.foreign_given && w_lis) begin
                        r_lis_v <= 1'b1;
                        r_lis_i <= w_i;
                    end
                    default: ;
                endcase
                r_i <= r_i + CntW'(1);
            end
        end
    end
endmodule

FILE: sv/tcp_connection_table.sv
// Release, write, get and undefined commands pass once through the scan state; allocate,
// lookup and port commands scan the table until their search stops, at most at entry EntryCount - 1.
// The execution unit handles one item at a time and takes no new one until its result
// is accepted; the table scan checks one entry per cycle.
// Reset (synchronous, active low) frees every entry at once; no clearing pass.
module tcp_connection_table import tct_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command, entry_index, local_addr, local_port, foreign_given,
    // foreign_addr, remote_port, new_state
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit, found_index, found_state, zero pad
    output logic [15:0]  m_axis_tdata
);
    `include "tcp_connection_table_macros.svh"

    logic f_valid, e_ready;
    t_req w_req;
    t_res w_res;

    tct_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_valid(f_valid), .i_ready(e_ready), .o_req(w_req)
    );

    tct_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(e_ready), .i_req(w_req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {3'b000, w_res.state, w_res.index, w_res.hit};

    `TCT_ASSERT(a_miss_zero, m_axis_tvalid && !w_res.hit |-> m_axis_tdata == 16'd0,
        "miss result not zero")
    `TCT_ASSERT(a_idx_range, m_axis_tvalid |-> w_res.index < 8'(EntryCount) || !w_res.hit,
        "hit index out of range")
    `TCT_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !m_axis_tvalid, "result after reset")
endmodule

FILE: tb/tb.sv
module tb;
    import tct_pkg::*;

    localparam int IdleLimit = 4000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // command, entry_index, local_addr, local_port, foreign_given,
    // foreign_addr, remote_port, new_state
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // hit, found_index, found_state, zero pad
    logic [15:0]  m_axis_tdata;

    tcp_connection_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Declared from the top bit down so that command lands in the lowest bits.
    typedef struct packed {
        logic [3:0]  new_state;
        logic [15:0] remote_port;
        logic [31:0] foreign_addr;
        logic        foreign_given;
        logic [15:0] local_port;
        logic [31:0] local_addr;
        logic [7:0]  entry_index;
        logic [2:0]  command;
    } t_cmd_item;

    class conn_scoreboard;
        logic [31:0] laddr[EntryCount];
        logic [15:0] lport[EntryCount];
        logic [31:0] faddr[EntryCount];
        logic [15:0] fport[EntryCount];
        logic [3:0]  status[EntryCount];
        t_res        pending[$];
        int          errors;
        int          hits;
        int          checked;

        function void clear_all();
            for (int i = 0; i < EntryCount; i++) begin
                laddr[i] = '0; lport[i] = '0; faddr[i] = '0; fport[i] = '0;
                status[i] = StFree;
            end
            errors = 0; hits = 0; checked = 0;
        endfunction

        function t_res make(bit hit, int idx);
            t_res r;
            r = '0;
            if (hit) begin
                r.hit = 1'b1;
                r.index = idx[7:0];
                r.state = status[idx];
            end
            return r;
        endfunction

        function void note_command(t_cmd_item c);
            t_res r;
            bit   in_rng;
            bit   have_listen;
            int   listen_idx;
            bit   done;
            in_rng = c.entry_index < EntryCount;
            r = '0;
            done = 0;
            case (c.command)
                CMD_ALLOC: begin
                    for (int i = 0; i < EntryCount && !done; i++)
                        if (status[i] == StFree) begin
                            status[i] = StClosed;
                            r = make(1, i);
                            done = 1;
                        end
                end
                CMD_FREE: if (in_rng) begin
                    laddr[c.entry_index] = '0; lport[c.entry_index] = '0;
                    faddr[c.entry_index] = '0; fport[c.entry_index] = '0;
                    status[c.entry_index] = StFree;
                    r = make(1, c.entry_index);
                end
                CMD_WRITE: if (in_rng) begin
                    laddr[c.entry_index] = c.local_addr;
                    lport[c.entry_index] = c.local_port;
                    faddr[c.entry_index] = c.foreign_addr;
                    fport[c.entry_index] = c.remote_port;
                    status[c.entry_index] = c.new_state;
                    r = make(1, c.entry_index);
                end
                CMD_LOOKUP: begin
                    have_listen = 0;
                    listen_idx = 0;
                    for (int i = 0; i < EntryCount && !done; i++) begin
                        if ((laddr[i] == AddrWild || laddr[i] == c.local_addr) &&
                            lport[i] == c.local_port) begin
                            if (!c.foreign_given || (faddr[i] == c.foreign_addr &&
                                fport[i] == c.remote_port)) begin
                                r = make(1, i);
                                done = 1;
                            end else if (status[i] == StListen && faddr[i] == AddrWild
                                         && fport[i] == 16'd0) begin
                                have_listen = 1;
                                listen_idx = i;
                            end
                        end
                    end
                    if (!done && have_listen)
                        r = make(1, listen_idx);
                end
                CMD_PORT: begin
                    for (int i = 0; i < EntryCount && !done; i++)
                        if (lport[i] == c.local_port) begin
                            r = make(1, i);
                            done = 1;
                        end
                end
                CMD_GET: if (in_rng && status[c.entry_index] != StFree)
                    r = make(1, c.entry_index);
                default: r = '0;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] data);
            t_res got;
            t_res want;
            got.hit = data[0];
            got.index = data[8:1];
            got.state = data[12:9];
            checked++;
            if (data[15:13] != 3'b0) begin
                $display("%0t: pad bits expected 0 actual %h", $time, data[15:13]);
                errors++;
            end
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.hit) hits++;
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                errors++;
            end
            if (got.index !== want.index) begin
                $display("%0t: found_index expected %0d actual %0d", $time, want.index,
                         got.index);
                errors++;
            end
            if (got.state !== want.state) begin
                $display("%0t: found_state expected %0d actual %0d", $time, want.state,
                         got.state);
                errors++;
            end
        endfunction
    endclass

    conn_scoreboard conns;
    int idle_cycles = 0;
    int sent;

    // A small pool of endpoints so lookups actually find entries.
    logic [31:0] addr_pool[4] = '{32'h0A00_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'hC0A8_0102};
    logic [15:0] port_pool[4] = '{16'd80, 16'hFFFF, 16'd0, 16'd443};

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            conns.note_command(t_cmd_item'(s_axis_tdata));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            conns.check_result(m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver side: random stalls, with calm stretches.
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = ((sent / 200) % 3 == 1) ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_command(t_cmd_item c);
        int gap;
        gap = ((sent / 200) % 3 == 1) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    function automatic t_cmd_item random_command(bit noisy);
        t_cmd_item c;
        c.command = noisy ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
        c.entry_index = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                        8'($urandom_range(0, EntryCount - 1));
        c.local_addr = noisy ? $urandom : addr_pool[$urandom_range(0, 3)];
        c.local_port = noisy ? 16'($urandom) : port_pool[$urandom_range(0, 3)];
        c.foreign_given = 1'($urandom);
        c.foreign_addr = noisy ? $urandom : addr_pool[$urandom_range(0, 3)];
        c.remote_port = noisy ? 16'($urandom) : port_pool[$urandom_range(0, 3)];
        c.new_state = ($urandom_range(0, 2) == 0) ? StListen : 4'($urandom);
        return c;
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (conns.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_cmd_item c;
        conns = new();
        conns.clear_all();
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, fill it, overflow, extremes and special cases.
        c = '0;
        c.command = CMD_GET; send_command(c);
        c.command = CMD_LOOKUP; send_command(c);
        for (int i = 0; i < EntryCount + 1; i++) begin
            c = '0; c.command = CMD_ALLOC; send_command(c);
        end
        c = '1; c.command = CMD_WRITE; c.entry_index = 8'(EntryCount - 1);
        c.new_state = StListen; c.foreign_addr = '0; c.remote_port = '0;
        send_command(c);
        c.command = CMD_LOOKUP; c.foreign_addr = '1; send_command(c);
        c.command = CMD_FREE; c.entry_index = 8'hFF; send_command(c);
        c.command = CMD_WRITE; send_command(c);
        c.command = CMD_GET; send_command(c);
        c.command = 3'd6; send_command(c);
        c.command = 3'd7; send_command(c);
        c.command = CMD_PORT; c.local_port = 16'hFFFF; send_command(c);
        drain();

        // Pool-based traffic for most items, raw noise for the rest.
        for (int n = 0; n < 1530; n++) begin
            send_command(random_command($urandom_range(0, 5) == 0));
            if (n == 700) drain();
        end
        drain();

        repeat (30) @(posedge i_clk);
        $display("Sent %0d commands, checked %0d results, %0d of them hits.",
                 sent, conns.checked, conns.hits);
        if (conns.errors == 0 && conns.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= IdleLimit) begin
                $display("Watchdog: no transfer for %0d cycles.", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end
endmodule
